@@ rtl/sha512_pkg.sv @@
// Package for the SHA-512 stream hasher: round constants, initial hash values
// and the round functions. No dependencies.
`timescale 1ns / 1ps
package sha512_pkg;

   localparam int BlockBytes  = 128;
   localparam int BlockWords  = BlockBytes / 8;
   localparam int RoundCount  = 80;
   localparam int DigestWords = 8;

   typedef logic [63:0] word_type;

   function automatic word_type iv_word(input logic [2:0] idx);
      word_type r;
      unique case (idx)
         3'd0: r = 64'h6a09e667f3bcc908;
         3'd1: r = 64'hbb67ae8584caa73b;
         3'd2: r = 64'h3c6ef372fe94f82b;
         3'd3: r = 64'ha54ff53a5f1d36f1;
         3'd4: r = 64'h510e527fade682d1;
         3'd5: r = 64'h9b05688c2b3e6c1f;
         3'd6: r = 64'h1f83d9abfb41bd6b;
         3'd7: r = 64'h5be0cd19137e2179;
         default: r = '0;
      endcase
      return r;
   endfunction

   localparam word_type RoundK [RoundCount] = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f,
      64'he9b5dba58189dbbc, 64'h3956c25bf348b538, 64'h59f111f1b605d019,
      64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118, 64'hd807aa98a3030242,
      64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235,
      64'hc19bf174cf692694, 64'he49b69c19ef14ad2, 64'hefbe4786384f25e3,
      64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65, 64'h2de92c6f592b0275,
      64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f,
      64'hbf597fc7beef0ee4, 64'hc6e00bf33da88fc2, 64'hd5a79147930aa725,
      64'h06ca6351e003826f, 64'h142929670a0e6e70, 64'h27b70a8546d22ffc,
      64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6,
      64'h92722c851482353b, 64'ha2bfe8a14cf10364, 64'ha81a664bbc423001,
      64'hc24b8b70d0f89791, 64'hc76c51a30654be30, 64'hd192e819d6ef5218,
      64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99,
      64'h34b0bcb5e19b48a8, 64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb,
      64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3, 64'h748f82ee5defb2fc,
      64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915,
      64'hc67178f2e372532b, 64'hca273eceea26619c, 64'hd186b8c721c0c207,
      64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178, 64'h06f067aa72176fba,
      64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc,
      64'h431d67c49c100d4c, 64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a,
      64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};

   function automatic word_type rotr(input word_type x, input int n);
      return (x >> n) | (x << (64 - n));
   endfunction

   function automatic word_type sig0(input word_type x);
      return rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
   endfunction

   function automatic word_type sig1(input word_type x);
      return rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
   endfunction

   function automatic word_type big0(input word_type x);
      return rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
   endfunction

   function automatic word_type big1(input word_type x);
      return rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
   endfunction

endpackage

@@ rtl/sha512_stream_hasher.sv @@
// SHA-512 stream hasher top level: word intake, padding and digest output.
// Depends on sha512_pkg and sha512_core.
`timescale 1ns / 1ps
// Usage:
//   The req_ channel carries the message as big-endian 64-bit words. Every
//   word carries 8 bytes; the word with req_last set carries req_byte_count
//   leading bytes (values above 8 count as 8, 0 is an empty final word).
//   After the last word the rsp_ channel delivers eight digest beats, index 0
//   first, with rsp_last_word on the eighth.
//   A word is written straight into the block RAM. Every sixteenth word
//   starts a compression (prefetch, 80 rounds, fold) in the single round
//   unit, handed off through StStart and StWait; no word is taken
//   meanwhile. The final word adds padding: one or two compressions, each
//   after up to 16 fill words, then the digest beats.
//   After reset the hash holds the initial values and the buffer is empty;
//   no clearing pass is needed. If the receiver stalls, the current digest
//   beat holds and no new word is taken until all eight beats have gone.
//   The hash state returns to the initial values after the eighth beat.
module sha512_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_data_word,
   input  logic [3:0]  req_byte_count,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);
   localparam int Words = sha512_pkg::BlockWords;
   localparam int SlotW = $clog2(Words);

   localparam logic [2:0] StIn    = 3'd0;  // taking words
   localparam logic [2:0] StWait  = 3'd1;  // waiting for any block compression, the final one included
   localparam logic [2:0] StFill  = 3'd2;  // writing padding words
   localparam logic [2:0] StFin   = 3'd3;  // unused; the final compression also runs in StWait
   localparam logic [2:0] StOut   = 3'd4;  // digest beats
   localparam logic [2:0] StStart = 3'd5;  // the cycle after start, core busy

   logic [2:0]       st_ff, st_in;
   logic [SlotW-1:0] slot_ff, slot_in;
   logic [63:0]      total_ff, total_in;
   logic             two_ff, two_in;    // the lone 0x80 word is still to be written
   logic             fin_ff, fin_in;    // the running compression is the last
   logic             pad_ff, pad_in;    // padding of the message is under way
   logic             roll_ff, roll_in;  // this block has no room for the length
   logic [2:0]       oidx_ff, oidx_in;

   logic             ld_en;
   logic [3:0]       ld_addr;
   logic [63:0]      ld_data, pad_word, keep;
   logic [3:0]       cnt;
   logic             start, restart, busy;
   logic [63:0]      hash_word;

   sha512_core u_core (
      .clock(clock), .reset(reset), .ld_en(ld_en), .ld_addr(ld_addr),
      .ld_data(ld_data), .start(start), .restart(restart), .busy(busy),
      .hash_sel(oidx_ff), .hash_word(hash_word)
   );

   assign req_ready       = (st_ff == StIn);
   assign rsp_valid       = (st_ff == StOut);
   assign rsp_digest_word = hash_word;
   assign rsp_word_index  = oidx_ff;
   assign rsp_last_word   = (oidx_ff == 3'd7);
   assign restart         = rsp_valid && rsp_ready && (oidx_ff == 3'd7);

   assign cnt  = (req_byte_count > 4'd8) ? 4'd8 : req_byte_count;
   assign keep = (cnt == 4'd0) ? 64'd0 : ~64'd0 << (7'd64 - {cnt, 3'b000});
   assign pad_word = (req_data_word & keep) | (64'h80 << (6'd56 - {cnt[2:0], 3'b000}));

   always_comb begin
      st_in    = st_ff;
      slot_in  = slot_ff;
      total_in = total_ff;
      two_in   = two_ff;
      fin_in   = fin_ff;
      pad_in   = pad_ff;
      roll_in  = roll_ff;
      oidx_in  = oidx_ff;
      ld_en    = 1'b0;
      ld_addr  = 4'(slot_ff);
      ld_data  = req_data_word;
      start    = 1'b0;
      unique case (st_ff)
         StIn: if (req_valid) begin
            ld_en   = 1'b1;
            slot_in = slot_ff + 1'b1;
            if (!req_last) begin
               total_in = total_ff + 64'd8;
               if (slot_ff == SlotW'(Words - 1)) begin
                  start  = 1'b1;
                  st_in  = StStart;
                  fin_in = 1'b0;
               end
            end else begin
               total_in = total_ff + 64'(cnt);
               pad_in   = 1'b1;
               if (cnt == 4'd8) begin
                  // full word, then a lone 0x80 word in the next slot
                  two_in  = 1'b1;
                  roll_in = (slot_ff == SlotW'(Words - 3));
               end else begin
                  ld_data = pad_word;
                  two_in  = 1'b0;
                  roll_in = (slot_ff == SlotW'(Words - 2));
               end
               // A word in the last slot fills the block: compress it at once.
               if (slot_ff == SlotW'(Words - 1)) begin
                  start  = 1'b1;
                  fin_in = 1'b0;
                  st_in  = StStart;
               end else begin
                  st_in = StFill;
               end
            end
         end
         StStart: st_in = StWait;
         StWait: if (!busy) begin
            // back from a compression: continue where the message stands
            if (fin_ff) begin
               st_in = StOut;
               oidx_in = '0;
            end else if (pad_ff) begin
               st_in = StFill;
            end else begin
               st_in = StIn;
            end
         end
         StFill: begin
            ld_en   = 1'b1;
            ld_data = '0;
            slot_in = slot_ff + 1'b1;
            if (two_ff) begin
               ld_data = 64'h8000000000000000;
               two_in  = 1'b0;
               if (slot_ff == SlotW'(Words - 1)) begin
                  start  = 1'b1;
                  fin_in = 1'b0;
                  st_in  = StStart;
               end
            end else if (roll_ff) begin
               // no room for the length: zero-fill and compress this block first
               if (slot_ff == SlotW'(Words - 1)) begin
                  start   = 1'b1;
                  fin_in  = 1'b0;
                  roll_in = 1'b0;
                  st_in   = StStart;
               end
            end else if (slot_ff == SlotW'(Words - 2)) begin
               ld_data = total_ff >> 61;
            end else if (slot_ff == SlotW'(Words - 1)) begin
               ld_data = total_ff << 3;
               start   = 1'b1;
               fin_in  = 1'b1;
               pad_in  = 1'b0;
               st_in   = StStart;
            end
         end
         StOut: if (rsp_ready) begin
            oidx_in = oidx_ff + 3'd1;
            if (oidx_ff == 3'd7) begin
               st_in    = StIn;
               total_in = '0;
               slot_in  = '0;
            end
         end
         default: st_in = StIn;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= StIn;
         slot_ff  <= '0;
         total_ff <= '0;
         two_ff   <= 1'b0;
         fin_ff   <= 1'b0;
         pad_ff   <= 1'b0;
         roll_ff  <= 1'b0;
         oidx_ff  <= '0;
      end else begin
         st_ff    <= st_in;
         slot_ff  <= slot_in;
         total_ff <= total_in;
         two_ff   <= two_in;
         fin_ff   <= fin_in;
         pad_ff   <= pad_in;
         roll_ff  <= roll_in;
         oidx_ff  <= oidx_in;
      end
   end
endmodule

@@ rtl/sha512_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
module sha512_ram #(
   parameter int Width = 64,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

@@ rtl/sha512_core.sv @@
// SHA-512 compression engine: one round per cycle over a 16-entry schedule RAM.
// Depends on sha512_pkg and sha512_ram.
`timescale 1ns / 1ps
module sha512_core (
   input  logic                 clock,
   input  logic                 reset,
   // loader writes the block into the schedule RAM while the core is idle
   input  logic                 ld_en,
   input  logic [3:0]           ld_addr,
   input  sha512_pkg::word_type ld_data,
   input  logic                 start,
   input  logic                 restart,
   output logic                 busy,
   input  logic [2:0]           hash_sel,
   output sha512_pkg::word_type hash_word
);
   // Phases: read prefetch, then 80 rounds, then fold into the hash.
   localparam logic [1:0] PhIdle  = 2'd0;
   localparam logic [1:0] PhPre   = 2'd1;
   localparam logic [1:0] PhRound = 2'd2;
   localparam logic [1:0] PhFold  = 2'd3;

   logic [1:0] ph_ff, ph_in;
   logic [6:0] rnd_ff, rnd_in;
   sha512_pkg::word_type h_ff [8];
   sha512_pkg::word_type v_ff [8];
   // sliding window of the last 16 schedule words, oldest at index 0
   sha512_pkg::word_type w_ff [16];

   logic                 ram_we;
   logic [3:0]           ram_wa, ram_ra;
   sha512_pkg::word_type ram_wd, ram_rd;

   sha512_ram #(.Width(64), .Depth(sha512_pkg::BlockWords)) u_sched (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(ram_wd),
      .rd_addr(ram_ra), .rd_data(ram_rd)
   );

   sha512_pkg::word_type w_cur, w_new, t1, t2, ch, mj;

   assign ram_we = ld_en;
   assign ram_wa = ld_addr;
   assign ram_wd = ld_data;
   // rounds 0..15 take words straight from the RAM, read an address ahead
   assign ram_ra = (ph_ff == PhRound) ? rnd_ff[3:0] + 4'd1 : 4'd0;

   assign w_new = sha512_pkg::sig1(w_ff[14]) + w_ff[9]
                + sha512_pkg::sig0(w_ff[1]) + w_ff[0];
   assign w_cur = (rnd_ff < 7'd16) ? ram_rd : w_new;
   assign ch = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
   assign mj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
   assign t1 = v_ff[7] + sha512_pkg::big1(v_ff[4]) + ch
             + sha512_pkg::RoundK[rnd_ff] + w_cur;
   assign t2 = sha512_pkg::big0(v_ff[0]) + mj;

   assign busy      = (ph_ff != PhIdle);
   assign hash_word = h_ff[hash_sel];

   always_comb begin
      ph_in  = ph_ff;
      rnd_in = rnd_ff;
      unique case (ph_ff)
         PhIdle:  if (start) ph_in = PhPre;
         PhPre: begin
            ph_in  = PhRound;
            rnd_in = '0;
         end
         PhRound: begin
            rnd_in = rnd_ff + 7'd1;
            if (rnd_ff == 7'(sha512_pkg::RoundCount - 1)) ph_in = PhFold;
         end
         PhFold:  ph_in = PhIdle;
         default: ph_in = PhIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff  <= PhIdle;
         rnd_ff <= '0;
      end else begin
         ph_ff  <= ph_in;
         rnd_ff <= rnd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         for (int i = 0; i < 8; i++) h_ff[i] <= sha512_pkg::iv_word(3'(i));
      end else if (ph_ff == PhFold) begin
         for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (ph_ff == PhPre) begin
         for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
      end else if (ph_ff == PhRound) begin
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= w_cur;
      end
   end
endmodule

@@ rtl/sha512_checker.sv @@
// Port-level checker for the SHA-512 stream hasher, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
module sha512_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_digest_word,
   input logic [2:0]  rsp_word_index,
   input logic        rsp_last_word
);
   a_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_word == (rsp_word_index == 3'd7)))
      else $error("last_word flag disagrees with index");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && req_ready))
      else $error("input taken while digest is out");
   a_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_word |=>
      rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1)
      else $error("digest beats not consecutive");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_digest_word))
      else $error("stalled digest beat changed");
endmodule

bind sha512_stream_hasher sha512_checker u_checker (
   .clock(clock), .reset(reset), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_digest_word(rsp_digest_word), .rsp_word_index(rsp_word_index),
   .rsp_last_word(rsp_last_word)
);
